// File: src/dcq_pkg.sv
`default_nettype none
package dcq_pkg;

	localparam int FRAC_BITS = 30;
	localparam int MAT_W     = 32;
	localparam int QUAT_W    = 32;
	localparam int EPS_W     = 21;
	localparam int EPS_RESET = 16;
	localparam int ADDR_W    = 3;
	localparam int APB_W     = 32;

	// Register byte offsets, decoded on paddr[ADDR_W-1:2]
	localparam logic REG_NORM_EPSILON = 1'b0;

	localparam int IN_W      = 9 * MAT_W;
	localparam int OUT_W     = 4 * QUAT_W;

	localparam int T_W       = 34;
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 3;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = FRAC_BITS + 1;
	localparam int PIPE_DEPTH = 3 * (SQ_STEPS + 1) + DIV_STEPS + 1 + 6;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [RAD_W-1:0] ONE_RAD = RAD_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0]     neg;
		logic [T_W-1:0] tz;
		logic [T_W-1:0] ty;
		logic [T_W-1:0] tx;
	} dcq_item_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} dcq_root_t;

	typedef struct packed {
		logic [ROOT_W-1:0]    rem;
		logic [DIV_STEPS-1:0] bits;
		logic [DIV_STEPS-1:0] quo;
	} dcq_div_t;

	typedef struct packed {
		logic [2:0]        neg;
		logic [ROOT_W-1:0] mz;
		logic [ROOT_W-1:0] my;
		logic [ROOT_W-1:0] mx;
		logic [ROOT_W-1:0] mw;
	} dcq_mags_t;

endpackage
`default_nettype wire

// File: src/dcm_to_quaternion.sv
`default_nettype none
// channel      dir  payload
// s_axis       in   m00..m22 in tdata, 32 bits each
// m_axis       out  quat_w..quat_z in tdata, degenerate in tuser
// apb          in   norm_epsilon at byte offset 0
//
// Fully pipelined: one matrix per cycle while the result side accepts, built
// from three 32-digit square roots and 31-bit dividers.
// No clearing pass after reset; norm_epsilon resets to 16.
// A four-entry queue absorbs up to four transactions once the result side
// stalls, then s_axis_tready drops; the back pipeline holds while a result waits.
module dcm_to_quaternion (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	input  logic [dcq_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z
	output logic [dcq_pkg::OUT_W-1:0]  m_axis_tdata,
	// degenerate
	output logic                       m_axis_tuser,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dcq_pkg::ADDR_W-1:0] paddr,
	input  logic [dcq_pkg::APB_W-1:0]  pwdata,
	output logic [dcq_pkg::APB_W-1:0]  prdata,
	output logic                       pready
);
	import dcq_pkg::*;

	dcq_item_t        push_item, pop_item;
	logic             push, full, pop, not_empty;
	logic [EPS_W-1:0] eps;

	dcq_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.norm_epsilon (eps)
	);

	dcq_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.fifo_full     (full),
		.push          (push),
		.item          (push_item)
	);

	dcq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_item   (push_item),
		.full      (full),
		.pop       (pop),
		.rd_item   (pop_item),
		.not_empty (not_empty)
	);

	dcq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (pop_item),
		.item_valid   (not_empty),
		.item_pop     (pop),
		.norm_epsilon (eps),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.quat_w       (m_axis_tdata[0*QUAT_W +: QUAT_W]),
		.quat_x       (m_axis_tdata[1*QUAT_W +: QUAT_W]),
		.quat_y       (m_axis_tdata[2*QUAT_W +: QUAT_W]),
		.quat_z       (m_axis_tdata[3*QUAT_W +: QUAT_W]),
		.degenerate   (m_axis_tuser)
	);

endmodule
`default_nettype wire

// File: src/dcq_cfg.sv
`default_nettype none
module dcq_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dcq_pkg::ADDR_W-1:0] paddr,
	input  logic [dcq_pkg::APB_W-1:0]  pwdata,
	output logic [dcq_pkg::APB_W-1:0]  prdata,
	output logic                       pready,
	output logic [dcq_pkg::EPS_W-1:0]  norm_epsilon
);
	import dcq_pkg::*;

	logic [EPS_W-1:0] eps_q;
	logic             hit;

	assign pready       = 1'b1;
	assign hit          = (paddr[ADDR_W-1:2] == REG_NORM_EPSILON);
	assign norm_epsilon = eps_q;
	assign prdata       = hit ? APB_W'(eps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_W'(EPS_RESET);
		end else if (psel && penable && pwrite && pready && hit) begin
			eps_q <= pwdata[EPS_W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: src/dcq_front.sv
`default_nettype none
module dcq_front (
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [dcq_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                      fifo_full,
	output logic                      push,
	output dcq_pkg::dcq_item_t        item
);
	import dcq_pkg::*;

	localparam int EW = T_W + 1;

	logic signed [EW-1:0] e00, e11, e22, one_e, tx, ty, tz;
	logic [MAT_W:0]       dx, dy, dz;

	function automatic logic signed [EW-1:0] sx(input logic [MAT_W-1:0] a);
		return $signed({{(EW-MAT_W){a[MAT_W-1]}}, a});
	endfunction

	function automatic logic [T_W-1:0] mag(input logic signed [EW-1:0] t);
		logic [EW-1:0] u;
		u = t[EW-1] ? EW'(-t) : EW'(t);
		return u[T_W-1:0];
	endfunction

	function automatic logic [MAT_W:0] diff(input logic [MAT_W-1:0] a,
		input logic [MAT_W-1:0] b);
		return {a[MAT_W-1], a} - {b[MAT_W-1], b};
	endfunction

	assign e00   = sx(s_axis_tdata[0*MAT_W +: MAT_W]);
	assign e11   = sx(s_axis_tdata[4*MAT_W +: MAT_W]);
	assign e22   = sx(s_axis_tdata[8*MAT_W +: MAT_W]);
	assign one_e = $signed(EW'(1) << FRAC_BITS);

	assign tx = one_e + e00 - e11 - e22;
	assign ty = one_e - e00 + e11 - e22;
	assign tz = one_e - e00 - e11 + e22;

	// antisymmetric differences m21-m12, m02-m20, m10-m01
	assign dx = diff(s_axis_tdata[7*MAT_W +: MAT_W], s_axis_tdata[5*MAT_W +: MAT_W]);
	assign dy = diff(s_axis_tdata[2*MAT_W +: MAT_W], s_axis_tdata[6*MAT_W +: MAT_W]);
	assign dz = diff(s_axis_tdata[3*MAT_W +: MAT_W], s_axis_tdata[1*MAT_W +: MAT_W]);

	assign item.tx  = mag(tx);
	assign item.ty  = mag(ty);
	assign item.tz  = mag(tz);
	assign item.neg = {dz[MAT_W], dy[MAT_W], dx[MAT_W]};

	assign s_axis_tready = !fifo_full;
	assign push          = s_axis_tvalid && !fifo_full;

endmodule
`default_nettype wire

// File: src/dcq_fifo.sv
`default_nettype none
module dcq_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dcq_pkg::dcq_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output dcq_pkg::dcq_item_t rd_item,
	output logic               not_empty
);
	import dcq_pkg::*;

	dcq_item_t             mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push, do_pop;

	assign full      = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("queue count overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == FIFO_CNT_W'(FIFO_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

// File: src/dcq_back.sv
`default_nettype none
module dcq_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dcq_pkg::dcq_item_t          item,
	input  logic                        item_valid,
	output logic                        item_pop,
	input  logic [dcq_pkg::EPS_W-1:0]   norm_epsilon,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dcq_pkg::QUAT_W-1:0]  quat_w,
	output logic [dcq_pkg::QUAT_W-1:0]  quat_x,
	output logic [dcq_pkg::QUAT_W-1:0]  quat_y,
	output logic [dcq_pkg::QUAT_W-1:0]  quat_z,
	output logic                        degenerate
);
	import dcq_pkg::*;

	function automatic dcq_root_t root_init(input logic [RAD_W-1:0] rad);
		dcq_root_t r;
		r.rad  = rad;
		r.rem  = '0;
		r.root = '0;
		return r;
	endfunction

	// one restoring square-root digit
	function automatic dcq_root_t root_step(input dcq_root_t s);
		dcq_root_t        n;
		logic [REM_W-1:0] cur, trial;
		cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		n.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			n.rem  = cur - trial;
			n.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = cur;
			n.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	function automatic dcq_div_t div_init(input logic [ROOT_W-1:0] m);
		dcq_div_t d;
		d.rem  = {1'b0, m[ROOT_W-1:1]};
		d.bits = {m[0], {FRAC_BITS{1'b0}}};
		d.quo  = '0;
		return d;
	endfunction

	// one restoring quotient bit of (m << FRAC_BITS) / norm
	function automatic dcq_div_t div_step(input dcq_div_t s, input logic [ROOT_W-1:0] d);
		dcq_div_t          n;
		logic [ROOT_W:0]   cur;
		cur    = {s.rem, s.bits[DIV_STEPS-1]};
		n.bits = {s.bits[DIV_STEPS-2:0], 1'b0};
		if (cur >= {1'b0, d}) begin
			n.rem = ROOT_W'(cur - {1'b0, d});
			n.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			n.rem = cur[ROOT_W-1:0];
			n.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
		end
		return n;
	endfunction

	function automatic logic [RAD_W-1:0] w_rad(input logic [RAD_W-1:0] sq);
		logic [RAD_W:0] d, u;
		d = {1'b0, ONE_RAD} - {1'b0, sq >> FRAC_BITS};
		u = d[RAD_W] ? -d : d;
		return u[RAD_W-1:0] << FRAC_BITS;
	endfunction

	function automatic logic [QUAT_W-1:0] apply_sign(input logic [DIV_STEPS-1:0] q,
		input logic neg);
		logic [QUAT_W-1:0] m;
		m = QUAT_W'(q);
		return neg ? -m : m;
	endfunction

	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  en;

	assign out_valid = vld_q[PIPE_DEPTH-1];
	assign en        = !out_valid || out_ready;
	assign item_pop  = en && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], item_valid};
		end
	end

	// x, y, z magnitude roots
	dcq_root_t  rx_s1 [SQ_STEPS+1];
	dcq_root_t  ry_s1 [SQ_STEPS+1];
	dcq_root_t  rz_s1 [SQ_STEPS+1];
	logic [2:0] neg_s1 [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1[0]  <= root_init(RAD_W'(item.tx) << (FRAC_BITS - 2));
			ry_s1[0]  <= root_init(RAD_W'(item.ty) << (FRAC_BITS - 2));
			rz_s1[0]  <= root_init(RAD_W'(item.tz) << (FRAC_BITS - 2));
			neg_s1[0] <= item.neg;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sq1
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s1[j]  <= root_step(rx_s1[j-1]);
				ry_s1[j]  <= root_step(ry_s1[j-1]);
				rz_s1[j]  <= root_step(rz_s1[j-1]);
				neg_s1[j] <= neg_s1[j-1];
			end
		end
	end

	dcq_mags_t        mg_s2, mg_s3;
	logic [RAD_W-1:0] x2_s2, y2_s2, z2_s2, sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mg_s2.mw  <= '0;
			mg_s2.mx  <= rx_s1[SQ_STEPS].root;
			mg_s2.my  <= ry_s1[SQ_STEPS].root;
			mg_s2.mz  <= rz_s1[SQ_STEPS].root;
			mg_s2.neg <= neg_s1[SQ_STEPS];
			x2_s2     <= RAD_W'(rx_s1[SQ_STEPS].root) * RAD_W'(rx_s1[SQ_STEPS].root);
			y2_s2     <= RAD_W'(ry_s1[SQ_STEPS].root) * RAD_W'(ry_s1[SQ_STEPS].root);
			z2_s2     <= RAD_W'(rz_s1[SQ_STEPS].root) * RAD_W'(rz_s1[SQ_STEPS].root);
			mg_s3     <= mg_s2;
			sq_s3     <= x2_s2 + y2_s2 + z2_s2;
		end
	end

	// scalar root
	dcq_root_t        rw_s5 [SQ_STEPS+1];
	dcq_mags_t        mg_s5 [SQ_STEPS+1];
	logic [RAD_W-1:0] sq_s5 [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rw_s5[0] <= root_init(w_rad(sq_s3));
			mg_s5[0] <= mg_s3;
			sq_s5[0] <= sq_s3;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sq2
		always_ff @(posedge clk) begin
			if (en) begin
				rw_s5[j] <= root_step(rw_s5[j-1]);
				mg_s5[j] <= mg_s5[j-1];
				sq_s5[j] <= sq_s5[j-1];
			end
		end
	end

	dcq_mags_t        mg_s6, mg_s7;
	logic [RAD_W-1:0] w2_s6, sq_s6, tot_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			mg_s6.mw  <= rw_s5[SQ_STEPS].root;
			mg_s6.mx  <= mg_s5[SQ_STEPS].mx;
			mg_s6.my  <= mg_s5[SQ_STEPS].my;
			mg_s6.mz  <= mg_s5[SQ_STEPS].mz;
			mg_s6.neg <= mg_s5[SQ_STEPS].neg;
			w2_s6     <= RAD_W'(rw_s5[SQ_STEPS].root) * RAD_W'(rw_s5[SQ_STEPS].root);
			sq_s6     <= sq_s5[SQ_STEPS];
			mg_s7     <= mg_s6;
			tot_s7    <= w2_s6 + sq_s6;
		end
	end

	// norm root
	dcq_root_t rn_s8 [SQ_STEPS+1];
	dcq_mags_t mg_s8 [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s8[0] <= root_init(tot_s7);
			mg_s8[0] <= mg_s7;
		end
	end

	for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sq3
		always_ff @(posedge clk) begin
			if (en) begin
				rn_s8[j] <= root_step(rn_s8[j-1]);
				mg_s8[j] <= mg_s8[j-1];
			end
		end
	end

	dcq_mags_t         mg_s9;
	logic [ROOT_W-1:0] norm_s9;
	logic              deg_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			mg_s9   <= mg_s8[SQ_STEPS];
			norm_s9 <= rn_s8[SQ_STEPS].root;
			deg_s9  <= rn_s8[SQ_STEPS].root <= ROOT_W'(norm_epsilon);
		end
	end

	// four quotient lanes share the norm
	dcq_div_t          dw_s10 [DIV_STEPS+1];
	dcq_div_t          dx_s10 [DIV_STEPS+1];
	dcq_div_t          dy_s10 [DIV_STEPS+1];
	dcq_div_t          dz_s10 [DIV_STEPS+1];
	logic [ROOT_W-1:0] nm_s10 [DIV_STEPS+1];
	logic [2:0]        neg_s10 [DIV_STEPS+1];
	logic              deg_s10 [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dw_s10[0]  <= div_init(mg_s9.mw);
			dx_s10[0]  <= div_init(mg_s9.mx);
			dy_s10[0]  <= div_init(mg_s9.my);
			dz_s10[0]  <= div_init(mg_s9.mz);
			nm_s10[0]  <= norm_s9;
			neg_s10[0] <= mg_s9.neg;
			deg_s10[0] <= deg_s9;
		end
	end

	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dw_s10[j]  <= div_step(dw_s10[j-1], nm_s10[j-1]);
				dx_s10[j]  <= div_step(dx_s10[j-1], nm_s10[j-1]);
				dy_s10[j]  <= div_step(dy_s10[j-1], nm_s10[j-1]);
				dz_s10[j]  <= div_step(dz_s10[j-1], nm_s10[j-1]);
				nm_s10[j]  <= nm_s10[j-1];
				neg_s10[j] <= neg_s10[j-1];
				deg_s10[j] <= deg_s10[j-1];
			end
		end
	end

	logic [QUAT_W-1:0] qw_q, qx_q, qy_q, qz_q;
	logic              deg_q;
	logic [2:0]        neg_l;

	assign neg_l = neg_s10[DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q <= deg_s10[DIV_STEPS];
			if (deg_s10[DIV_STEPS]) begin
				qw_q <= QUAT_W'(ONE_RAD);
				qx_q <= '0;
				qy_q <= '0;
				qz_q <= '0;
			end else begin
				qw_q <= apply_sign(dw_s10[DIV_STEPS].quo, 1'b0);
				qx_q <= apply_sign(dx_s10[DIV_STEPS].quo, neg_l[0]);
				qy_q <= apply_sign(dy_s10[DIV_STEPS].quo, neg_l[1]);
				qz_q <= apply_sign(dz_s10[DIV_STEPS].quo, neg_l[2]);
			end
		end
	end

	assign quat_w     = qw_q;
	assign quat_x     = qx_q;
	assign quat_y     = qy_q;
	assign quat_z     = qz_q;
	assign degenerate = deg_q;

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(quat_x) <= $signed(QUAT_W'(ONE_RAD)) &&
			$signed(quat_x) >= -$signed(QUAT_W'(ONE_RAD)) &&
			$signed(quat_w) >= 0))
		else $error("quaternion component exceeds unit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_z) && $stable(degenerate))
		else $error("result changed under stall");

endmodule
`default_nettype wire

// File: test/tb_dcm_to_quaternion.sv
`default_nettype none
module tb_dcm_to_quaternion;
	import dcq_pkg::*;

	localparam int LATENCY = 160;
	localparam longint LIMIT = 2000000;
	localparam longint ONE_Q = 64'd1 << FRAC_BITS;

	typedef struct {
		logic [QUAT_W-1:0] w, x, y, z;
		logic              degen;
	} quat_t;

	class quat_scoreboard;
		quat_t pending[$];
		int    errors;
		int    matched;

		function void note_matrix(quat_t q);
			pending.push_back(q);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_quat(logic [OUT_W-1:0] data, logic degen);
			quat_t q;
			if (pending.size() == 0) begin
				report($sformatf("unexpected quaternion %h", data));
				return;
			end
			q = pending.pop_front();
			if (data[31:0] !== q.w || data[63:32] !== q.x || data[95:64] !== q.y ||
					data[127:96] !== q.z || degen !== q.degen) begin
				report($sformatf("quat got %h/%b want %h%h%h%h/%b",
					data, degen, q.z, q.y, q.x, q.w, q.degen));
			end else
				matched++;
		endtask
	endclass

	logic               clk, arst_n;
	logic               s_axis_tvalid, s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata;
	logic               m_axis_tvalid, m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               m_axis_tuser;
	logic               psel, penable, pwrite, pready;
	logic [ADDR_W-1:0]  paddr;
	logic [APB_W-1:0]   pwdata, prdata;

	quat_scoreboard sb;
	logic [EPS_W-1:0] eps_model;
	longint cycles;
	int     hold_long;
	int     degen_seen;

	dcm_to_quaternion i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag_of(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic quat_t convert_dcm(logic [IN_W-1:0] d);
		longint a[9];
		longint unsigned mg[4], sq, s, nrm;
		longint rem;
		logic neg[4];
		logic [31:0] o[4];
		quat_t q;
		for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[32*i +: 32]));
		mg[1] = isqrt(mag_of(ONE_Q + a[0] - a[4] - a[8]) << (FRAC_BITS - 2));
		mg[2] = isqrt(mag_of(ONE_Q - a[0] + a[4] - a[8]) << (FRAC_BITS - 2));
		mg[3] = isqrt(mag_of(ONE_Q - a[0] - a[4] + a[8]) << (FRAC_BITS - 2));
		sq = mg[1]*mg[1] + mg[2]*mg[2] + mg[3]*mg[3];
		s = sq >> FRAC_BITS;
		rem = ONE_Q - longint'(s);
		mg[0] = isqrt(mag_of(rem) << FRAC_BITS);
		neg[0] = 0;
		neg[1] = (a[7] - a[5]) < 0;
		neg[2] = (a[2] - a[6]) < 0;
		neg[3] = (a[3] - a[1]) < 0;
		nrm = isqrt(mg[0]*mg[0] + sq);
		if (nrm <= eps_model) begin
			q.w = ONE_Q[31:0]; q.x = 0; q.y = 0; q.z = 0; q.degen = 1;
			return q;
		end
		for (int i = 0; i < 4; i++) begin
			o[i] = 32'((mg[i] << FRAC_BITS) / nrm);
			if (neg[i]) o[i] = -o[i];
		end
		q.w = o[0]; q.x = o[1]; q.y = o[2]; q.z = o[3]; q.degen = 0;
		return q;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// input transactions recorded as accepted
	always @(posedge clk)
		if (arst_n && s_axis_tvalid && s_axis_tready) sb.note_matrix(convert_dcm(s_axis_tdata));

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (m_axis_tuser) degen_seen++;
			sb.check_quat(m_axis_tdata, m_axis_tuser);
		end

	// receiver stall pattern; a long hold-off when requested
	always @(posedge clk) begin
		if (hold_long > 0) begin
			m_axis_tready <= 0;
			hold_long <= hold_long - 1;
		end else
			m_axis_tready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
	end

	task automatic apb_write(logic [EPS_W-1:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		eps_model = v;
	endtask

	task automatic send_matrix(logic [IN_W-1:0] d);
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain;
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'h4000_0000;
			2: return 32'hC000_0000;
			3: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
			default: return 32'(int'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
		endcase
	endfunction

	// random matrices: near-identity mixes, a (1, -1, -1) diagonal with random off-diagonals, or random entries
	function automatic logic [IN_W-1:0] rand_matrix();
		logic [IN_W-1:0] d;
		int k;
		k = $urandom_range(0, 3);
		for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_entry();
		if (k == 0) begin
			for (int i = 0; i < 9; i++)
				d[32*i +: 32] = (i % 4 == 0) ? 32'h4000_0000 - $urandom_range(0, 4096)
					: 32'(int'($urandom_range(0, 8192)) - 4096);
		end else if (k == 1) begin
			d[0 +: 32] = 32'h4000_0000;
			d[128 +: 32] = 32'hC000_0000;
			d[256 +: 32] = 32'hC000_0000;
		end
		return d;
	endfunction

	task automatic run_random(int n);
		int burst;
		int gap;
		while (n > 0) begin
			burst = $urandom_range(1, 30);
			for (int i = 0; i < burst && n > 0; i++, n--) send_matrix(rand_matrix());
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0; hold_long = 0; degen_seen = 0;
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		eps_model = EPS_W'(EPS_RESET);
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity, quarter turns, extremes, zero and degenerate cases
		send_matrix({32'h4000_0000, 96'd0, 32'h4000_0000, 96'd0, 32'h4000_0000});
		send_matrix({32'h4000_0000, 32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'hC000_0000,
			32'h0, 32'h4000_0000, 32'h0});
		send_matrix({32'h4000_0000, 32'h0, 32'hC000_0000, 32'h0, 32'h0, 32'h4000_0000,
			32'h0, 32'h4000_0000, 32'h0});
		send_matrix('0);
		send_matrix('1);
		send_matrix({9{32'h7FFF_FFFF}});
		send_matrix({9{32'h8000_0000}});
		send_matrix({9{32'h5555_5555}});
		send_matrix({9{32'hAAAA_AAAA}});
		// half turns: w exactly zero, s equals one
		send_matrix({32'hC000_0000, 96'd0, 32'hC000_0000, 96'd0, 32'h4000_0000});
		send_matrix({32'h4000_0000, 96'd0, 32'hC000_0000, 96'd0, 32'hC000_0000});
		// diagonal of minus ones: s above one
		send_matrix({32'hC000_0000, 96'd0, 32'hC000_0000, 96'd0, 32'hC000_0000});
		drain();

		apb_write('0);
		send_matrix({32'hC000_0000, 96'd0, 32'hC000_0000, 96'd0, 32'hC000_0000});
		send_matrix('0);
		run_random(350);
		drain();

		apb_write(21'h1F_FFFF);
		run_random(300);
		drain();

		apb_write(21'h10_0000);
		// long receiver hold-off while the sender keeps offering
		hold_long = 400;
		run_random(300);
		drain();

		// pause the sender until all results are in, then continue
		apb_write(21'h00_0400);
		run_random(300);
		drain();
		apb_write(EPS_W'(EPS_RESET));
		run_random(300);
		drain();

		$display("Converted %0d matrices, %0d degenerate, over five epsilon settings.",
			sb.matched, degen_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// File: dcm_to_quaternion.f
src/dcq_pkg.sv
src/dcq_cfg.sv
src/dcq_front.sv
src/dcq_fifo.sv
src/dcq_back.sv
src/dcm_to_quaternion.sv
test/tb_dcm_to_quaternion.sv
